### src/isd_pkg.sv
// Shared constants, types and register codes for the interval average spike detector.
// No dependencies; imported by every module of the block.
package isd_pkg;

  localparam int unsigned WINDOW_DEPTH = 16;

  localparam int unsigned TICK_W  = 24;
  localparam int unsigned DECAY_W = 17;
  localparam int unsigned LIMIT_W = 16;

  // count holds 0..WINDOW_DEPTH, slot holds 0..WINDOW_DEPTH-1
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SUM_W  = TICK_W + CNT_W;
  localparam int unsigned ITER_W = $clog2(SUM_W);
  localparam int unsigned ACC_W  = DECAY_W + TICK_W;

  localparam logic [DECAY_W-1:0] DECAY_ONE  = DECAY_W'(32'd65536);
  localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(32'd32768);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABSOLUTE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELATIVE_LIMIT = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] ticks;
    logic              abs_hit;
  } isd_item_t;

  typedef struct packed {
    logic [DECAY_W-1:0] decay_factor;
    logic [LIMIT_W-1:0] relative_limit;
  } isd_cfg_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } isd_qstat_t;

endpackage

### src/isd_front.sv
// Front end: takes sample beats, runs the absolute limit test, queues them (2 deep).
// Depends on isd_pkg.
module isd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [isd_pkg::TICK_W-1:0] ticks_i,
  input  logic [isd_pkg::TICK_W-1:0] abs_limit_i,
  output logic                      full_o,
  output isd_pkg::isd_item_t        item_o,
  output logic                      item_valid_o,
  input  logic                      item_take_i,
  output isd_pkg::isd_qstat_t       stat_o
);
  import isd_pkg::*;

  isd_item_t   entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push_ok, take_ok;
  isd_item_t   new_item;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entry_q[rd_ptr_q];
  assign push_ok      = push_i && !full_o;
  assign take_ok      = item_take_i && item_valid_o;

  assign stat_o.full     = full_o;
  assign stat_o.nonempty = item_valid_o;

  always_comb begin
    new_item.ticks   = ticks_i;
    new_item.abs_hit = (abs_limit_i != '0) && (ticks_i > abs_limit_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (take_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_ok && !take_ok) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (take_ok && !push_ok) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### src/isd_back.sv
// Back end: exponential average, sample ring with running sum, serial divider,
// relative spike tests on one shared multiplier, and the result register. Uses isd_pkg.
module isd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  isd_pkg::isd_item_t          item_i,
  input  logic                        item_valid_i,
  output logic                        item_take_o,
  input  isd_pkg::isd_cfg_t           cfg_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [isd_pkg::TICK_W-1:0]  decayed_average_o,
  output logic [isd_pkg::TICK_W-1:0]  window_average_o,
  output logic                        spike_o
);
  import isd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECA = 3'd1;
  localparam logic [2:0] S_DECB = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SPA  = 3'd4;
  localparam logic [2:0] S_SPB  = 3'd5;
  localparam logic [2:0] S_SPC  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]         state_q, state_d;

  // per-item working registers
  logic [TICK_W-1:0]  x_q, old_q, dec_q, win_q;
  logic               hit_q;
  logic [DECAY_W-1:0] f_q;
  logic [ACC_W-1:0]   acc_q;
  logic [SUM_W-1:0]   quo_q;
  logic [CNT_W-1:0]   rem_q;
  logic [ITER_W-1:0]  iter_q;

  // persistent state
  logic [TICK_W-1:0]  decay_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TICK_W-1:0]  ring_mem [WINDOW_DEPTH];

  // result register
  logic               out_valid_q;
  logic [TICK_W-1:0]  out_dec_q, out_win_q;
  logic               out_spike_q;

  logic               take, ring_full, out_free, div_ge;
  logic [DECAY_W-1:0] mul_a;
  logic [TICK_W-1:0]  mul_b;
  logic [ACC_W-1:0]   mul_p, x_scaled;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W:0]     trial, trial_sub;
  logic [TICK_W-1:0]  dec_new;

  assign take        = (state_q == S_IDLE) && item_valid_i;
  assign item_take_o = take;
  assign ring_full   = (cnt_q == CNT_W'(WINDOW_DEPTH));
  assign out_free    = !out_valid_q || pop_i;

  assign empty_o           = !out_valid_q;
  assign decayed_average_o = out_dec_q;
  assign window_average_o  = out_win_q;
  assign spike_o           = out_spike_q;

  // one shared multiplier
  always_comb begin
    case (state_q)
      S_DECA: begin
        mul_a = f_q;
        mul_b = decay_q;
      end
      S_DECB: begin
        mul_a = DECAY_ONE - f_q;
        mul_b = x_q;
      end
      S_SPA: begin
        mul_a = {1'b0, cfg_i.relative_limit};
        mul_b = dec_q;
      end
      S_SPB: begin
        mul_a = {1'b0, cfg_i.relative_limit};
        mul_b = win_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = {{TICK_W{1'b0}}, mul_a} * {{DECAY_W{1'b0}}, mul_b};
  assign x_scaled = {{(ACC_W-TICK_W-8){1'b0}}, x_q, 8'h00};

  assign sum_next = sum_q + SUM_W'(x_q) - (ring_full ? SUM_W'(old_q) : '0);

  // restoring divide, one quotient bit per cycle
  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign trial_sub = trial - {1'b0, cnt_q};
  assign div_ge    = (trial >= {1'b0, cnt_q});

  // seed when the average is zero, else round to nearest
  assign dec_new = (decay_q == '0) ? x_q : acc_q[16 +: TICK_W];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (item_valid_i) state_d = S_DECA;
      S_DECA: state_d = S_DECB;
      S_DECB: state_d = S_DIV;
      S_DIV:  if (iter_q == ITER_W'(SUM_W - 1)) state_d = S_SPA;
      S_SPA:  state_d = S_SPB;
      S_SPB:  state_d = S_SPC;
      S_SPC:  state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sample ring: registered read at take, write once the slot is read
  always_ff @(posedge clk_i) begin
    if (take) begin
      old_q <= ring_mem[slot_q];
    end
    if (state_q == S_DECA) begin
      ring_mem[slot_q] <= x_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q   <= item_i.ticks;
        hit_q <= item_i.abs_hit;
        f_q   <= cfg_i.decay_factor[DECAY_W-1] ? DECAY_ONE : cfg_i.decay_factor;
      end
      S_DECA: begin
        acc_q  <= mul_p + ROUND_HALF;
        quo_q  <= sum_next;
        rem_q  <= '0;
        iter_q <= '0;
      end
      S_DECB: begin
        acc_q <= acc_q + mul_p;
      end
      S_DIV: begin
        if (iter_q == '0) begin
          dec_q <= dec_new;
        end
        rem_q  <= div_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_q  <= {quo_q[SUM_W-2:0], div_ge};
        iter_q <= iter_q + ITER_W'(1);
      end
      S_SPA: begin
        win_q <= quo_q[TICK_W-1:0];
        acc_q <= mul_p;
      end
      S_SPB: begin
        hit_q <= hit_q | (x_scaled > acc_q);
        acc_q <= mul_p;
      end
      S_SPC: begin
        hit_q <= hit_q | (x_scaled > acc_q);
      end
      default: begin
      end
    endcase
    if (state_q == S_OUT && out_free) begin
      out_dec_q   <= dec_q;
      out_win_q   <= win_q;
      out_spike_q <= hit_q;
    end
  end

  // control and persistent averaging state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      decay_q     <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DECA) begin
        sum_q  <= sum_next;
        slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
        if (!ring_full) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (state_q == S_DIV && iter_q == '0) begin
        decay_q <= dec_new;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### src/interval_average_spike_detector.sv
// Top level of the interval average spike detector: configuration registers,
// front queue and back end. Depends on isd_pkg, isd_front and isd_back.
//
// Usage:
//  - Input channel: a beat carries one measured interval (interval_ticks_i) and
//    is taken on a clock edge with push high and full low. A 2-deep queue in the
//    front end keeps taking beats while the back end is busy.
//  - Result channel: while empty is low the oldest result sits on the result
//    ports; it is taken on an edge with pop high. One result per input beat.
//  - Config channel: cfg_ready_o is always high; index 0 decay factor, 1 absolute
//    limit, 2 relative limit, index 3 ignored. Write only while the block is idle.
//  - Back end: each beat runs through 1 take, 2 multiply steps, SUM_W = 29 divider
//    steps, 3 spike steps and 1 result load; the serial divide of the window sum
//    by the held count is the longest part. empty drops once the result load is
//    done, and the back end takes no new beat until its last one is loaded.
//  - Stall: if pop stays low, the back end holds its finished beat until the
//    result register frees up; the front queue fills and full rises.
//  - Reset: averages, window sum, held count and slot clear; decay factor resets
//    to 1.0, limits to zero. Ring contents are not cleared (slots read only after
//    they are written).
module interval_average_spike_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            push,
  output logic                            full,
  input  logic [isd_pkg::TICK_W-1:0]      interval_ticks_i,
  // result channel
  output logic                            empty,
  input  logic                            pop,
  output logic [isd_pkg::TICK_W-1:0]      decayed_average_o,
  output logic [isd_pkg::TICK_W-1:0]      window_average_o,
  output logic                            spike_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [isd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [isd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import isd_pkg::*;

  logic [DECAY_W-1:0] decay_factor_q;
  logic [TICK_W-1:0]  absolute_limit_q;
  logic [LIMIT_W-1:0] relative_limit_q;

  isd_item_t  item;
  logic       item_valid, item_take;
  isd_cfg_t   back_cfg;
  isd_qstat_t qstat;

  assign cfg_ready_o = 1'b1;

  // config registers; unknown index drops the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_factor_q   <= DECAY_ONE;
      absolute_limit_q <= '0;
      relative_limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DECAY_FACTOR:   decay_factor_q   <= cfg_data_i[DECAY_W-1:0];
        REG_ABSOLUTE_LIMIT: absolute_limit_q <= cfg_data_i[TICK_W-1:0];
        REG_RELATIVE_LIMIT: relative_limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign back_cfg.decay_factor   = decay_factor_q;
  assign back_cfg.relative_limit = relative_limit_q;

  isd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .ticks_i      (interval_ticks_i),
    .abs_limit_i  (absolute_limit_q),
    .full_o       (full),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .stat_o       (qstat)
  );

  isd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item),
    .item_valid_i      (item_valid),
    .item_take_o       (item_take),
    .cfg_i             (back_cfg),
    .pop_i             (pop),
    .empty_o           (empty),
    .decayed_average_o (decayed_average_o),
    .window_average_o  (window_average_o),
    .spike_o           (spike_o)
  );

  // back end only takes a beat the queue actually holds
  a_take_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |-> item_valid)
    else $error("back end took a beat from an empty queue");

  // back end works on one beat at a time
  a_take_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take |=> !item_take)
    else $error("back end took two beats in consecutive cycles");

  // queue status stays consistent
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> qstat.nonempty)
    else $error("front queue reports full but holds nothing");

endmodule

### test/interval_average_checker.sv
// Checker for the interval average spike detector: watches the input, config
// and result channels, predicts both averages and the spike flag, compares.
// Depends on isd_pkg for widths and register codes.
module interval_average_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic                           full_i,
  input  logic [isd_pkg::TICK_W-1:0]     ticks_i,
  input  logic                           empty_i,
  input  logic                           pop_i,
  input  logic [isd_pkg::TICK_W-1:0]     decayed_i,
  input  logic [isd_pkg::TICK_W-1:0]     window_i,
  input  logic                           spike_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [isd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [isd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             spikes_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import isd_pkg::*;

  localparam int          RING_DEPTH = WINDOW_DEPTH;
  localparam logic [16:0] UNITY      = 17'h10000;

  typedef struct packed {
    logic [TICK_W-1:0] decayed;
    logic [TICK_W-1:0] window;
    logic              spike;
  } averages_t;

  // register copies
  logic [16:0]       decay_weight = UNITY;
  logic [TICK_W-1:0] abs_ceiling  = '0;
  logic [15:0]       ratio_q8     = '0;

  // running state
  logic [TICK_W-1:0] decay_avg    = '0;
  logic [TICK_W-1:0] ring [RING_DEPTH];
  logic [31:0]       window_total = '0;
  int                held         = 0;
  int                slot         = 0;

  averages_t pending_averages [$];
  int        mismatches = 0;
  int        checked    = 0;
  int        spikes     = 0;

  // x*256 against avg*ratio, exact
  function automatic bit beyond_ratio(input logic [TICK_W-1:0] ticks,
                                      input logic [TICK_W-1:0] avg);
    return (64'(ticks) << 8) > (64'(avg) * 64'(ratio_q8));
  endfunction

  function automatic averages_t fold_interval(input logic [TICK_W-1:0] ticks);
    logic [63:0] weight;
    logic [63:0] acc;
    averages_t   r;
    weight = (decay_weight > UNITY) ? 64'(UNITY) : 64'(decay_weight);
    // zero average means unseeded: the sample takes over
    if (decay_avg == '0) begin
      r.decayed = ticks;
    end else begin
      acc = weight * 64'(decay_avg) + (64'h10000 - weight) * 64'(ticks) + 64'h8000;
      r.decayed = acc[16 +: TICK_W];
    end
    decay_avg = r.decayed;
    window_total = window_total + 32'(ticks);
    if (held == RING_DEPTH) begin
      window_total = window_total - 32'(ring[slot]);
    end else begin
      held++;
    end
    ring[slot] = ticks;
    slot = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
    r.window = TICK_W'(window_total / 32'(held));
    r.spike = (abs_ceiling != '0 && ticks > abs_ceiling) ||
              beyond_ratio(ticks, r.decayed) || beyond_ratio(ticks, r.window);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    averages_t want;
    if (!rst_ni) begin
      decay_weight = UNITY;
      abs_ceiling = '0;
      ratio_q8 = '0;
      decay_avg = '0;
      window_total = '0;
      held = 0;
      slot = 0;
      pending_averages.delete();
    end else begin
      // result side first: it always belongs to an older beat
      if (pop_i && !empty_i) begin
        if (pending_averages.size() == 0) begin
          $display("%0t: result beat with nothing outstanding (dec %0d win %0d spike %0b)",
                   $time, decayed_i, window_i, spike_i);
          mismatches++;
        end else begin
          want = pending_averages.pop_front();
          checked++;
          if (spike_i) spikes++;
          if (decayed_i !== want.decayed) begin
            $display("%0t: decayed_average expected %0d got %0d",
                     $time, want.decayed, decayed_i);
            mismatches++;
          end
          if (window_i !== want.window) begin
            $display("%0t: window_average expected %0d got %0d",
                     $time, want.window, window_i);
            mismatches++;
          end
          if (spike_i !== want.spike) begin
            $display("%0t: spike expected %0b got %0b", $time, want.spike, spike_i);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DECAY_FACTOR:   decay_weight = cfg_data_i[16:0];
          REG_ABSOLUTE_LIMIT: abs_ceiling = cfg_data_i[TICK_W-1:0];
          REG_RELATIVE_LIMIT: ratio_q8 = cfg_data_i[15:0];
          default: ;  // unmapped index, dropped
        endcase
      end
      if (push_i && !full_i) begin
        pending_averages.push_back(fold_interval(ticks_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o <= pending_averages.size();
    checked_o <= checked;
    spikes_o <= spikes;
  end

endmodule

### test/interval_average_spike_detector_tb.sv
// Testbench top for the interval average spike detector: clock, reset, interval
// and register stimulus, result-side stalls, watchdog and verdict.
// Depends on isd_pkg, the block itself and interval_average_checker.
module interval_average_spike_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isd_pkg::*;

  localparam int                   STALL_LIMIT  = 5000;  // cycles with no beat at all
  localparam int                   SETTLE       = 40;    // wind-down margin for the back end
  localparam int                   PHASE_ITEMS  = 272;
  localparam int                   HOLD_AFTER   = 80;    // input beats before the long stall
  localparam int                   HOLD_CYCLES  = 600;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum int {DRAIN_ALL, COIN_FLIP, TRICKLE, ALTERNATE} pop_style_e;

  logic                  clk_i;
  logic                  rst_ni           = 1'b0;
  logic                  push             = 1'b0;
  logic                  full;
  logic [TICK_W-1:0]     interval_ticks_i = '0;
  logic                  empty;
  logic                  pop              = 1'b0;
  logic [TICK_W-1:0]     decayed_average_o;
  logic [TICK_W-1:0]     window_average_o;
  logic                  spike_o;
  logic                  cfg_valid_i      = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i       = '0;

  int fail_count, pending, checked, spikes;
  int beats_in    = 0;
  int beats_out   = 0;
  int full_cycles = 0;
  int quiet       = 0;
  int burst_left  = 1;
  int settings    = 0;

  // directed openers at reset settings: unseeded zeros, seed at max, bit
  // patterns, then enough beats to fill the ring and wrap it once
  logic [TICK_W-1:0] opening [17] = '{
    24'h000000, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000, 24'h7FFFFF,
    24'hAAAAAA, 24'h555555, 24'h000000, 24'hFFFFFF, 24'h000003, 24'hFFFFFF,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000002
  };

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  interval_average_spike_detector i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .interval_ticks_i (interval_ticks_i),
    .empty            (empty),
    .pop              (pop),
    .decayed_average_o(decayed_average_o),
    .window_average_o (window_average_o),
    .spike_o          (spike_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  interval_average_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .ticks_i      (interval_ticks_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .decayed_i    (decayed_average_o),
    .window_i     (window_average_o),
    .spike_i      (spike_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .spikes_o     (spikes)
  );

  // Beat bookkeeping and watchdog. Any beat on any channel resets the quiet
  // count; the long result hold-off is the longest legal quiet stretch.
  always @(posedge clk_i) begin
    if (push && !full) beats_in <= beats_in + 1;
    if (pop && !empty) beats_out <= beats_out + 1;
    if (push && full) full_cycles <= full_cycles + 1;
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one interval and hold it until the block takes it. push is left
  // high so back-to-back beats need no extra edge.
  task automatic send_interval(input logic [TICK_W-1:0] ticks);
    push <= 1'b1;
    interval_ticks_i <= ticks;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Bursty sender: random burst lengths, random gaps so that idle time
  // lands on every step of the back end; some long bursts without any
  // gap.
  task automatic send_paced(input logic [TICK_W-1:0] ticks);
    int gap;
    send_interval(ticks);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Registers only move while nothing is in flight: drop push, let the beat
  // counters catch up with the last accepting edge, wait for the last result,
  // then let the back end wind down.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (beats_out != beats_in) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all three registers back to back, optionally followed by a write
  // to the unmapped index, which the block must drop.
  task automatic set_registers(input logic [CFG_DATA_W-1:0] decay_word,
                               input logic [CFG_DATA_W-1:0] abs_word,
                               input logic [CFG_DATA_W-1:0] ratio_word,
                               input bit                    stray);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int                    n;
    idx[0] = REG_DECAY_FACTOR;   val[0] = decay_word;
    idx[1] = REG_ABSOLUTE_LIMIT; val[1] = abs_word;
    idx[2] = REG_RELATIVE_LIMIT; val[2] = ratio_word;
    idx[3] = REG_UNMAPPED;       val[3] = CFG_DATA_W'($urandom);
    n = stray ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // Interval mix: mostly a steady rhythm around the base so the relative
  // test is exercised near its edge, plus spikes, noise, tiny and extreme
  // values.
  function automatic logic [TICK_W-1:0] make_interval(input logic [TICK_W-1:0] base);
    longint v;
    longint spread;
    int     pick;
    pick = $urandom_range(0, 99);
    spread = longint'(base) / 4 + 1;
    if (pick < 60) begin
      v = longint'(base) - spread + longint'($urandom_range(0, 32'(2 * spread)));
    end else if (pick < 70) begin
      v = longint'(base) * $urandom_range(2, 6) + $urandom_range(0, 255);
    end else if (pick < 85) begin
      v = longint'($urandom & 32'hFFFFFF);
    end else if (pick < 95) begin
      v = $urandom_range(0, 3);
    end else if (pick < 98) begin
      v = 0;
    end else begin
      v = 24'hFFFFFF;
    end
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return TICK_W'(v);
  endfunction

  task automatic run_phase(input logic [TICK_W-1:0] base);
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      send_paced(make_interval(base));
    end
    settle();
  endtask

  // Result side: a pop style picked per span, and one long hold-off once
  // enough beats are in so the front queue fills and full rises while the
  // sender keeps offering.
  initial begin : result_side
    pop_style_e style;
    int         span;
    int         hold_left;
    int         tick;
    bit         hold_done;
    bit         want;
    hold_left = 0;
    hold_done = 1'b0;
    tick = 0;
    forever begin
      style = pop_style_e'($urandom_range(0, 3));
      span = $urandom_range(40, 300);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (!hold_done && beats_in >= HOLD_AFTER) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          want = 1'b0;
          hold_left--;
        end else begin
          case (style)
            DRAIN_ALL: want = 1'b1;
            COIN_FLIP: want = 1'($urandom_range(0, 1));
            TRICKLE:   want = ($urandom_range(0, 7) == 0);
            default:   want = ((tick / 6) % 2 == 0);
          endcase
        end
        pop <= want;
      end
    end
  end

  initial begin : stimulus
    logic [TICK_W-1:0] base;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: decay weight 1.0, no absolute limit, ratio zero so
    // every nonzero interval is a spike.
    foreach (opening[k]) send_paced(opening[k]);
    settle();

    // Zero weight: average follows the sample exactly; leave it at 1.
    set_registers(24'd0, 24'd100, 24'd256, 1'b0);
    send_paced(24'd1);
    settle();

    // Quarter weight on old 1 with sample 0 rounds the average to zero; the
    // next sample then seeds it again. 101 and 100 sit on the absolute limit.
    set_registers(24'd16384, 24'd100, 24'd256, 1'b0);
    send_paced(24'd0);
    send_paced(24'd5);
    send_paced(24'd101);
    send_paced(24'd100);
    send_paced(24'hFFFFFF);
    settle();

    // Random phases, one register setting each.
    set_registers(24'h0F000, 24'd0, 24'd384, 1'b0);
    run_phase(24'd1000);

    set_registers(24'd0, 24'hFFFFFF, 24'hFFFF, 1'b0);
    run_phase(TICK_W'($urandom_range(1, 24'hFFFFFF)));

    // weight above one, saturates to 1.0
    set_registers(24'h1FFFF, 24'd5000, 24'd256, 1'b0);
    run_phase(24'd3000);

    // random values with junk in the bits above each register's width
    set_registers({7'($urandom), 17'($urandom_range(0, 65536))},
                  CFG_DATA_W'($urandom),
                  {8'($urandom), 16'($urandom_range(0, 1023))}, 1'b0);
    base = TICK_W'($urandom >> $urandom_range(8, 31));
    run_phase(base);

    set_registers(24'h10000, 24'd1, 24'd0, 1'b1);
    run_phase(24'd200000);

    // tiny weight on small intervals: the average follows the sample almost exactly
    set_registers(24'd1, 24'd0, 24'd512, 1'b0);
    run_phase(24'd8);

    $display("run: %0d intervals in, %0d results checked, %0d spikes, %0d register settings",
             beats_in, checked, spikes, settings);
    $display("run: input held off by a full queue for %0d cycles", full_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
